>>> sv/bpb_pkg.sv
// ----------------------------------------------------------------------------
// bpb_pkg
// Shared types and constants for the bilinear pixel blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpb_pkg;

    localparam int PIX_W    = 32;   // pixel word
    localparam int NARROW_W = 16;   // pixel word in narrow mode
    localparam int FRAC_W   = 8;    // fraction in 1/256 units
    localparam int WGT_W    = 17;   // weight, up to 65536
    localparam int CH_W     = 8;    // one color channel
    localparam int SHIFT_W  = 5;    // channel bit position
    localparam int PROD_W   = 24;   // weight * channel, below 2^24
    localparam int SUM_W    = 26;   // four products, grown
    localparam int NPIX     = 4;    // neighbors per item
    localparam int IDX_W    = 3;    // configuration register index

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [WGT_W-1:0]   weight_t;
    typedef logic [CH_W-1:0]    chan_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [SUM_W-1:0]   sum_t;

    typedef pixel_t  pix_quad_t [NPIX];
    typedef weight_t wgt_quad_t [NPIX];

    // per-channel field layout
    typedef struct packed {
        shift_t shift;
        chan_t  max;
    } chan_cfg_t;

    typedef enum logic [IDX_W-1:0] {
        REG_RED_SHIFT   = 3'd0,
        REG_GREEN_SHIFT = 3'd1,
        REG_BLUE_SHIFT  = 3'd2,
        REG_RED_MAX     = 3'd3,
        REG_GREEN_MAX   = 3'd4,
        REG_BLUE_MAX    = 3'd5,
        REG_WIDE_PIXELS = 3'd6
    } reg_idx_t;

    localparam shift_t RED_SHIFT_RST   = 5'd16;
    localparam shift_t GREEN_SHIFT_RST = 5'd8;
    localparam shift_t BLUE_SHIFT_RST  = 5'd0;
    localparam chan_t  CH_MAX_RST      = 8'hFF;

endpackage

`default_nettype wire

>>> sv/bilinear_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// bilinear_pixel_blend_unit
// Bilinear blend of four neighboring true-color pixels by x/y fractions.
//
//   channel   signals                                    direction
//   command   start, busy, top_left..bottom_right,       in (busy out)
//             frac_x, frac_y
//   result    done, blended_pixel                        out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  in (ready out)
//
// Four-stage pipeline: weights, products, channel sums, repack. A result
// appears on done out of the repack register; one item per clock sustained.
// busy and cfg_ready are always low and high. Reset clears valid bits and
// loads the register defaults. The result is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_pixel_blend_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output      logic                   busy,
    input  wire bpb_pkg::pixel_t        top_left,
    input  wire bpb_pkg::pixel_t        top_right,
    input  wire bpb_pkg::pixel_t        bottom_left,
    input  wire bpb_pkg::pixel_t        bottom_right,
    input  wire logic [7:0]             frac_x,
    input  wire logic [7:0]             frac_y,
    output      logic                   done,
    output      bpb_pkg::pixel_t        blended_pixel,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data
);
    import bpb_pkg::*;

    // configuration registers
    chan_cfg_t red_cfg_reg, green_cfg_reg, blue_cfg_reg;
    logic      wide_reg;

    // stage valid bits
    logic [3:0] vld_reg;

    // stage 1 payload
    pix_quad_t pix_reg;
    pix_quad_t pix_next;
    wgt_quad_t wgt_reg;
    wgt_quad_t wgt_next;

    // stage 3 channels
    chan_t red_ch, green_ch, blue_ch;

    // stage 4 output
    pixel_t out_reg;
    pixel_t out_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cfg_reg   <= '{shift: RED_SHIFT_RST,   max: CH_MAX_RST};
            green_cfg_reg <= '{shift: GREEN_SHIFT_RST, max: CH_MAX_RST};
            blue_cfg_reg  <= '{shift: BLUE_SHIFT_RST,  max: CH_MAX_RST};
            wide_reg      <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_RED_SHIFT:   red_cfg_reg.shift   <= cfg_data[SHIFT_W-1:0];
                REG_GREEN_SHIFT: green_cfg_reg.shift <= cfg_data[SHIFT_W-1:0];
                REG_BLUE_SHIFT:  blue_cfg_reg.shift  <= cfg_data[SHIFT_W-1:0];
                REG_RED_MAX:     red_cfg_reg.max     <= cfg_data[CH_W-1:0];
                REG_GREEN_MAX:   green_cfg_reg.max   <= cfg_data[CH_W-1:0];
                REG_BLUE_MAX:    blue_cfg_reg.max    <= cfg_data[CH_W-1:0];
                REG_WIDE_PIXELS: wide_reg            <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage 1: mask pixels to size, build weights
    always_comb
    begin
        logic [FRAC_W:0] fx, fy, ifx, ify;
        logic [2*FRAC_W+1:0] w0, w1, w2, w3;
        pixel_t pmask;
        pmask = wide_reg ? '1 : PIX_W'({NARROW_W{1'b1}});
        pix_next[0] = top_left     & pmask;
        pix_next[1] = top_right    & pmask;
        pix_next[2] = bottom_left  & pmask;
        pix_next[3] = bottom_right & pmask;
        fx  = {1'b0, frac_x};
        fy  = {1'b0, frac_y};
        ifx = 9'd256 - fx;
        ify = 9'd256 - fy;
        w0  = ifx * ify;
        w1  = fx  * ify;
        w2  = ifx * fy;
        w3  = fx  * fy;
        wgt_next[0] = w0[WGT_W-1:0];
        wgt_next[1] = w1[WGT_W-1:0];
        wgt_next[2] = w2[WGT_W-1:0];
        wgt_next[3] = w3[WGT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        wgt_reg <= wgt_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], start && !busy};
    end

    // stages 2 and 3
    bpb_channel u_red (
        .clk  (clk),
        .pix  (pix_reg),
        .wgt  (wgt_reg),
        .cfg  (red_cfg_reg),
        .chan (red_ch)
    );

    bpb_channel u_green (
        .clk  (clk),
        .pix  (pix_reg),
        .wgt  (wgt_reg),
        .cfg  (green_cfg_reg),
        .chan (green_ch)
    );

    bpb_channel u_blue (
        .clk  (clk),
        .pix  (pix_reg),
        .wgt  (wgt_reg),
        .cfg  (blue_cfg_reg),
        .chan (blue_ch)
    );

    // stage 4: repack; bits pushed past bit 31 drop off, and narrow mode keeps bits 15:0 only
    always_comb
    begin
        pixel_t packed_px;
        packed_px = (PIX_W'(red_ch)   << red_cfg_reg.shift)
                  | (PIX_W'(green_ch) << green_cfg_reg.shift)
                  | (PIX_W'(blue_ch)  << blue_cfg_reg.shift);
        out_next  = wide_reg ? packed_px : {{(PIX_W-NARROW_W){1'b0}},
                                            packed_px[NARROW_W-1:0]};
    end

    assign done          = vld_reg[3];
    assign blended_pixel = out_reg;

endmodule

`default_nettype wire

>>> sv/bpb_channel.sv
// ----------------------------------------------------------------------------
// bpb_channel
// One color channel: extract from four pixels, weight, sum and scale down.
// Two register stages: products, then the scaled channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_channel (
    input  wire logic               clk,
    input  wire bpb_pkg::pix_quad_t pix,
    input  wire bpb_pkg::wgt_quad_t wgt,
    input  wire bpb_pkg::chan_cfg_t cfg,
    output      bpb_pkg::chan_t     chan
);
    import bpb_pkg::*;

    prod_t prod_reg [NPIX];
    prod_t prod_next [NPIX];
    chan_t chan_reg;
    chan_t chan_next;
    sum_t  sum;

    always_comb
    begin
        for (int k = 0; k < NPIX; k++)
        begin
            pixel_t down;
            chan_t  c;
            logic [WGT_W+CH_W-1:0] p;
            down = pix[k] >> cfg.shift;
            c    = down[CH_W-1:0] & cfg.max;
            p    = wgt[k] * c;
            // weights sum to 65536 and c <= 255, so p < 2^24
            prod_next[k] = p[PROD_W-1:0];
        end
    end

    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
            + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
        chan_next = sum[16 +: CH_W];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

>>> verif/tb_bilinear_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_bilinear_pixel_blend_unit
// Self-checking bench for the bilinear pixel blend unit. Pixel quads and
// fractions go in on the command port. A local copy of the channel layout
// registers predicts each blended pixel, which is compared with the value
// shown on the done strobe. Several channel layouts are visited, including
// narrow pixels, channels past the pixel edge and overlapping channels.
// ----------------------------------------------------------------------------
module tb_bilinear_pixel_blend_unit;
    import bpb_pkg::*;

    localparam int LATENCY         = 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RAND_PER_LAYOUT = 143;
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;   // index with no register behind it

    // predicts blended pixels from a shadow of the layout registers
    class blend_checker;
        shift_t red_shift;
        shift_t green_shift;
        shift_t blue_shift;
        chan_t  red_max;
        chan_t  green_max;
        chan_t  blue_max;
        bit     wide;
        pixel_t pending_pixels[$];
        int     mismatches;
        int     blends;
        int     reg_writes;

        function new();
            red_shift   = RED_SHIFT_RST;
            green_shift = GREEN_SHIFT_RST;
            blue_shift  = BLUE_SHIFT_RST;
            red_max     = CH_MAX_RST;
            green_max   = CH_MAX_RST;
            blue_max    = CH_MAX_RST;
            wide        = 1'b1;
            mismatches  = 0;
            blends      = 0;
            reg_writes  = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
            reg_writes++;
            case (idx)
                REG_RED_SHIFT:   red_shift   = data[SHIFT_W-1:0];
                REG_GREEN_SHIFT: green_shift = data[SHIFT_W-1:0];
                REG_BLUE_SHIFT:  blue_shift  = data[SHIFT_W-1:0];
                REG_RED_MAX:     red_max     = data[CH_W-1:0];
                REG_GREEN_MAX:   green_max   = data[CH_W-1:0];
                REG_BLUE_MAX:    blue_max    = data[CH_W-1:0];
                REG_WIDE_PIXELS: wide        = data[0];
                default: ;
            endcase
        endfunction

        function chan_t mix_channel(pix_quad_t pix, wgt_quad_t w, shift_t sh, chan_t mx);
            sum_t  acc;
            chan_t c;
            acc = '0;
            for (int k = 0; k < NPIX; k++)
            begin
                c = chan_t'(pix[k] >> sh) & mx;
                acc += w[k] * c;
            end
            return chan_t'(acc >> 16);
        endfunction

        function pixel_t blend_pixel(pix_quad_t p, logic [FRAC_W-1:0] fx,
                                     logic [FRAC_W-1:0] fy);
            pixel_t     pmask;
            pixel_t     px;
            pix_quad_t  q;
            wgt_quad_t  w;
            logic [8:0] ix;
            logic [8:0] iy;
            chan_t      r;
            chan_t      g;
            chan_t      b;
            pmask = wide ? '1 : pixel_t'({NARROW_W{1'b1}});
            for (int k = 0; k < NPIX; k++)
                q[k] = p[k] & pmask;
            ix   = 9'd256 - fx;
            iy   = 9'd256 - fy;
            w[0] = ix * iy;
            w[1] = fx * iy;
            w[2] = ix * fy;
            w[3] = fx * fy;
            r  = mix_channel(q, w, red_shift, red_max);
            g  = mix_channel(q, w, green_shift, green_max);
            b  = mix_channel(q, w, blue_shift, blue_max);
            // bits pushed past bit 31 fall off; overlapping fields OR together
            px = (pixel_t'(r) << red_shift) | (pixel_t'(g) << green_shift) |
                 (pixel_t'(b) << blue_shift);
            return px & pmask;
        endfunction

        function void take_request(pix_quad_t p, logic [FRAC_W-1:0] fx,
                                   logic [FRAC_W-1:0] fy);
            pending_pixels.push_back(blend_pixel(p, fx, fy));
            blends++;
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("blended_pixel: expected nothing, got %h", got);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    $error("blended_pixel: expected %h, got %h", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    pixel_t            top_left;
    pixel_t            top_right;
    pixel_t            bottom_left;
    pixel_t            bottom_right;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
    logic              done;
    pixel_t            blended_pixel;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [31:0]       cfg_data;

    blend_checker blend_chk;
    pix_quad_t    seen_quad;
    int           layouts;

    always #5 clk = ~clk;

    bilinear_pixel_blend_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .top_left      (top_left),
        .top_right     (top_right),
        .bottom_left   (bottom_left),
        .bottom_right  (bottom_right),
        .frac_x        (frac_x),
        .frac_y        (frac_y),
        .done          (done),
        .blended_pixel (blended_pixel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // transfer monitor: register writes, accepted commands, result strobes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                blend_chk.set_reg(cfg_index, cfg_data);
            if (start && !busy)
            begin
                seen_quad[0] = top_left;
                seen_quad[1] = top_right;
                seen_quad[2] = bottom_left;
                seen_quad[3] = bottom_right;
                blend_chk.take_request(seen_quad, frac_x, frac_y);
            end
            if (done)
                blend_chk.check_pixel(blended_pixel);
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = $urandom;
        case ($urandom_range(0, 3))
            1:
            begin
                for (int i = 0; i < 4; i++)
                    p[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: p = $urandom_range(0, 1) ? '1 : '0;
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [FRAC_W-1:0] rand_frac();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FRAC_W'($urandom_range(0, 255));
        endcase
    endfunction

    // start stays high between back-to-back items
    task automatic send_blend(pixel_t tl, pixel_t tr, pixel_t bl, pixel_t br,
                              logic [FRAC_W-1:0] fx, logic [FRAC_W-1:0] fy, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        top_left     <= tl;
        top_right    <= tr;
        bottom_left  <= bl;
        bottom_right <= br;
        frac_x       <= fx;
        frac_y       <= fy;
        do @(posedge clk); while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (blend_chk.pending_pixels.size() != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // upper data bits carry noise; the block must ignore them
    task automatic write_layout(shift_t rs, shift_t gs, shift_t bs,
                                chan_t rm, chan_t gm, chan_t bm, bit wd);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_RED_SHIFT, {junk[31:5], rs});
        junk = $urandom;
        write_reg(REG_GREEN_SHIFT, {junk[31:5], gs});
        junk = $urandom;
        write_reg(REG_BLUE_SHIFT, {junk[31:5], bs});
        write_reg(REG_NONE, $urandom);
        junk = $urandom;
        write_reg(REG_RED_MAX, {junk[31:8], rm});
        junk = $urandom;
        write_reg(REG_GREEN_MAX, {junk[31:8], gm});
        junk = $urandom;
        write_reg(REG_BLUE_MAX, {junk[31:8], bm});
        junk = $urandom;
        write_reg(REG_WIDE_PIXELS, {junk[31:1], wd});
        cfg_valid <= 1'b0;
        layouts++;
    endtask

    task automatic run_blends(int count, bit idle);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            gap = (idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
            send_blend(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(),
                       rand_frac(), rand_frac(), gap);
        end
        settle();
    endtask

    initial
    begin
        blend_chk    = new();
        layouts      = 1;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        top_left     <= '0;
        top_right    <= '0;
        bottom_left  <= '0;
        bottom_right <= '0;
        frac_x       <= '0;
        frac_y       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout: corner weights, full scale, alternating bits
        send_blend(32'h0, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 0);
        send_blend('1, '1, '1, '1, 8'd255, 8'd255, 0);
        send_blend(32'h00FF_0000, 32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 0);
        send_blend(32'h0, 32'h0000_FF00, 32'h0, 32'h0, 8'd255, 8'd0, 0);
        send_blend(32'h0, 32'h0, 32'h0000_00FF, 32'h0, 8'd0, 8'd255, 0);
        send_blend(32'h0, 32'h0, 32'h0, '1, 8'd255, 8'd255, 0);
        send_blend(32'h00FF_FFFF, 32'h0, 32'h0, 32'h00FF_FFFF, 8'd128, 8'd128, 0);
        send_blend(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                   8'd85, 8'd170, 2);
        send_blend(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000,
                   8'd1, 8'd1, 0);
        send_blend('1, '1, '1, '1, 8'd1, 8'd254, 0);
        send_blend(32'h00FF_FFFF, 32'h0, 32'h00FF_FFFF, 32'h0, 8'd255, 8'd0, 0);
        send_blend(32'h0012_3456, 32'h0065_4321, 32'h00FE_DCBA, 32'h00AB_CDEF,
                   8'd0, 8'd255, 0);
        run_blends(RAND_PER_LAYOUT, 1'b1);

        // narrow 5-6-5: upper halves of the inputs must not matter
        write_layout(5'd11, 5'd5, 5'd0, 8'd31, 8'd63, 8'd31, 1'b0);
        send_blend(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                   8'd0, 8'd0, 0);
        send_blend('1, '1, '1, '1, 8'd255, 8'd255, 0);
        send_blend(32'h0000_FFFF, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF,
                   8'd64, 8'd192, 0);
        run_blends(RAND_PER_LAYOUT, 1'b1);

        // every field at the top bit: channels read past the pixel, repack drops
        write_layout(5'd31, 5'd31, 5'd31, 8'd255, 8'd255, 8'd255, 1'b1);
        run_blends(RAND_PER_LAYOUT, 1'b1);
        write_layout(5'd0, 5'd0, 5'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        run_blends(RAND_PER_LAYOUT, 1'b1);
        // overlapping fields
        write_layout(5'd4, 5'd4, 5'd4, 8'd255, 8'd255, 8'd255, 1'b1);
        run_blends(RAND_PER_LAYOUT, 1'b1);
        // narrow pixels with fields wholly or partly above bit 15
        write_layout(5'd28, 5'd30, 5'd12, 8'd255, 8'd255, 8'd255, 1'b0);
        run_blends(RAND_PER_LAYOUT, 1'b1);
        write_layout(5'd0, 5'd8, 5'd16, 8'd255, 8'd128, 8'd127, 1'b1);
        run_blends(RAND_PER_LAYOUT, 1'b1);
        for (int n = 0; n < 2; n++)
        begin
            write_layout(shift_t'($urandom_range(0, 31)), shift_t'($urandom_range(0, 31)),
                         shift_t'($urandom_range(0, 31)), chan_t'($urandom_range(0, 255)),
                         chan_t'($urandom_range(0, 255)), chan_t'($urandom_range(0, 255)),
                         bit'($urandom_range(0, 1)));
            run_blends(RAND_PER_LAYOUT, 1'b1);
        end
        // back to defaults, full rate to the end
        write_layout(RED_SHIFT_RST, GREEN_SHIFT_RST, BLUE_SHIFT_RST,
                     CH_MAX_RST, CH_MAX_RST, CH_MAX_RST, 1'b1);
        run_blends(RAND_PER_LAYOUT, 1'b0);

        if (blend_chk.pending_pixels.size() != 0)
        begin
            $error("blended_pixel: %0d expected results never arrived",
                   blend_chk.pending_pixels.size());
            blend_chk.mismatches++;
        end
        $display("Summary: %0d pixel blends checked over %0d channel layouts",
                 blend_chk.blends, layouts);
        $display("Summary: %0d register writes, narrow and wide pixels, unmapped index",
                 blend_chk.reg_writes);
        if (blend_chk.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/bpb_pkg.sv
sv/bpb_channel.sv
sv/bilinear_pixel_blend_unit.sv
verif/tb_bilinear_pixel_blend_unit.sv
